>>> hdl/idl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types and codes of the indexed deque list: command and response
// words, command kinds and status codes.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_INSERT     = 3'd4;
    localparam logic [2:0] KIND_ERASE      = 3'd5;
    localparam logic [2:0] KIND_READ       = 3'd6;
    localparam logic [2:0] KIND_CLEAR      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [6:0]         position;
        logic signed [31:0] item;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } rsp_t;

    // Shift command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

>>> hdl/idl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_cell
// One storage cell of the list row. It loads the new word, takes its lower
// or upper neighbor's word, or holds, and offers its word to the read taps.
// ----------------------------------------------------------------------------
module idl_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                clk,
    input  idl_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       pos,
    input  logic [PW-1:0]       fill,
    input  logic signed [31:0]  item,
    input  logic signed [31:0]  lower,
    input  logic signed [31:0]  upper,
    input  logic [PW-1:0]       rpos,
    input  logic [PW-1:0]       fidx,
    output logic signed [31:0]  value,
    output logic signed [31:0]  rd_part,
    output logic signed [31:0]  fr_part
);
    import idl_pkg::*;

    localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
    localparam logic [PW-1:0] NXT_IDX = PW'(IDX + 1);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == pos)
            begin
                value_next = item;
            end
            else if (MY_IDX > pos && MY_IDX <= fill)
            begin
                value_next = lower;
            end
        end
        else if (ctrl.del)
        begin
            if (MY_IDX >= pos && NXT_IDX < fill)
            begin
                value_next = upper;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign rd_part = (MY_IDX == rpos) ? value_reg : 32'sd0;
    assign fr_part = (MY_IDX == fidx) ? value_reg : 32'sd0;

endmodule

>>> hdl/indexed_deque_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_list_top
// Bounded ordered list of signed 32-bit words held in a row of shifting
// cells, with push, pop, insert, erase, read and clear commands.
// ----------------------------------------------------------------------------
// Usage:
// A command word enters on cmd when cmd_valid is high and cmd_stall is low.
// Position 0 is the back end; position count-1 is the front end. Each
// command yields exactly one response word on rsp: the read value, the
// front and back words after the command, the count and a status.
// Insert and erase shift the whole cell row at once, so the block takes one
// command per clock while cmd_stall is low. The response word is registered:
// the accepting edge updates the cells and the pending stage, and the output
// register taps the cells when the pending stage advances.
// If the receiver stalls, the output register holds its word and one more
// command may be accepted into the pending stage; after that cmd_stall
// rises until the response is taken.
// Reset empties the list and drops any pending response; cell contents
// are not cleared and are never shown before they are written.
// ----------------------------------------------------------------------------
module indexed_deque_list_top #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  idl_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output idl_pkg::rsp_t rsp
);
    import idl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [PW-1:0] CAP_W = PW'(CAPACITY);

    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;

    logic          pend_valid_reg;
    logic          pend_rd_reg;
    logic [1:0]    pend_status_reg;
    logic [PW-1:0] pend_pos_reg;

    logic          rsp_valid_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    logic          accept;
    logic          advance;
    logic          full;
    logic          empty;
    logic [PW-1:0] pos_w;
    logic [1:0]    status;
    logic          rd_ok;
    cell_ctrl_t    ctrl;
    logic [PW-1:0] shift_pos;
    logic [PW-1:0] front_idx;

    logic signed [31:0] cell_value [CAPACITY];
    logic signed [31:0] rd_part    [CAPACITY];
    logic signed [31:0] fr_part    [CAPACITY];
    logic signed [31:0] rd_sum;
    logic signed [31:0] fr_sum;

    assign advance   = pend_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = pend_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign full  = (fill_reg == CAP_W);
    assign empty = (fill_reg == '0);
    assign pos_w = PW'(cmd.position);

    // Command decode against the current fill; rejected commands leave
    // the cells and the fill untouched.
    always_comb
    begin
        status    = ST_OK;
        rd_ok     = 1'b0;
        ctrl      = '0;
        shift_pos = '0;
        fill_next = fill_reg;
        unique case (cmd.kind)
            KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.ins  = 1'b1;
                    shift_pos = fill_reg;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.ins  = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            KIND_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    ctrl.del  = 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            KIND_INSERT:
            begin
                if (pos_w > fill_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.ins  = 1'b1;
                    shift_pos = pos_w;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_ERASE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_w >= fill_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctrl.del  = 1'b1;
                    shift_pos = pos_w;
                    fill_next = fill_reg - 1'b1;
                end
            end
            KIND_READ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_w >= fill_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!accept)
        begin
            ctrl      = '0;
            fill_next = fill_reg;
        end
    end

    assign front_idx = fill_reg - 1'b1;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] lower_w;
        logic signed [31:0] upper_w;

        if (g == 0)
        begin : g_first
            assign lower_w = 32'sd0;
        end
        else
        begin : g_mid_lo
            assign lower_w = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_w = 32'sd0;
        end
        else
        begin : g_mid_hi
            assign upper_w = cell_value[g+1];
        end

        idl_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .pos     (shift_pos),
            .fill    (fill_reg),
            .item    (cmd.item),
            .lower   (lower_w),
            .upper   (upper_w),
            .rpos    (pend_pos_reg),
            .fidx    (front_idx),
            .value   (cell_value[g]),
            .rd_part (rd_part[g]),
            .fr_part (fr_part[g])
        );
    end

    // At most one cell matches each tap, so the taps merge by OR.
    always_comb
    begin
        rd_sum = 32'sd0;
        fr_sum = 32'sd0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sum = rd_sum | rd_part[i];
            fr_sum = fr_sum | fr_part[i];
        end
    end

    always_comb
    begin
        rsp_next.read_value  = pend_rd_reg ? rd_sum : 32'sd0;
        rsp_next.front_value = (fill_reg != '0) ? fr_sum : 32'sd0;
        rsp_next.back_value  = (fill_reg != '0) ? cell_value[0] : 32'sd0;
        rsp_next.count       = fill_reg[6:0];
        rsp_next.status      = pend_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_rd_reg     <= rd_ok;
            pend_status_reg <= status;
            pend_pos_reg    <= pos_w;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hdl/idl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idl_checker
// Port-level checks of the indexed deque list, bound to the top level.
// ----------------------------------------------------------------------------
module idl_checker #(
    parameter int CAPACITY = 64
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input idl_pkg::rsp_t rsp
);
    import idl_pkg::*;

    localparam logic [6:0] CAP_COUNT = 7'(CAPACITY);

    // A stalled response word must hold.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // An empty list shows no front or back word.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.count == 7'd0 |-> rsp.front_value == 32'sd0
            && rsp.back_value == 32'sd0)
        else $error("empty list reports a front or back word");

    // A rejected command returns no read value.
    a_reject_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.read_value == 32'sd0)
        else $error("rejected command returned a read value");

    // A full status means the list really is at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.count == CAP_COUNT)
        else $error("full status below capacity");

    // An empty status means the list really holds nothing.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == 7'd0)
        else $error("empty status with stored words");

endmodule

bind indexed_deque_list_top idl_checker #(
    .CAPACITY (CAPACITY)
) u_idl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed deque list. A short table of directed
// commands, some with hand-written responses, is followed by random command
// runs. The runs grow and drain the list, hit the full and empty limits, and
// add noise. Each response is checked against its typed row or a shadow list.
// ----------------------------------------------------------------------------
module tb_top;

    import idl_pkg::*;

    localparam int LIST_CAP       = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 600;
    localparam int TAIL_CYCLES    = 16;

    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t r;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the list; position 0 is the back end.
    logic signed [31:0] shadow_words [LIST_CAP];
    int                 shadow_len = 0;
    rsp_t               expected_rsp_q [$];
    dir_row_t           directed_q [$];
    rsp_t               want_rsp;

    int fail_count    = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int accepted_cmds = 0;
    int stall_mode    = 0;
    int stall_run     = 0;

    logic [2:0] grow_kinds [3]   = '{KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT};
    logic [2:0] shrink_kinds [3] = '{KIND_POP_FRONT, KIND_POP_BACK, KIND_ERASE};
    logic [2:0] probe_kinds [4]  = '{KIND_POP_FRONT, KIND_POP_BACK, KIND_ERASE,
                                     KIND_READ};

    always #4 clk = ~clk;

    indexed_deque_list_top #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    function automatic rsp_t list_apply(cmd_t c);
        rsp_t r;
        int   pos;
        int   k;
        r   = '0;
        pos = int'(c.position);
        r.status = ST_OK;
        case (c.kind)
            KIND_PUSH_FRONT:
                if (shadow_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = c.item;
                    shadow_len++;
                end
            KIND_PUSH_BACK:
                if (shadow_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (k = shadow_len; k > 0; k--)
                        shadow_words[k] = shadow_words[k - 1];
                    shadow_words[0] = c.item;
                    shadow_len++;
                end
            KIND_POP_FRONT:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_len--;
            KIND_POP_BACK:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (k = 0; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k + 1];
                    shadow_len--;
                end
            KIND_INSERT:
                // The range test wins over the full test.
                if (pos > shadow_len)
                    r.status = ST_RANGE;
                else if (shadow_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (k = shadow_len; k > pos; k--)
                        shadow_words[k] = shadow_words[k - 1];
                    shadow_words[pos] = c.item;
                    shadow_len++;
                end
            KIND_ERASE:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k + 1];
                    shadow_len--;
                end
            KIND_READ:
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow_words[pos];
            default:
                shadow_len = 0;
        endcase
        if (shadow_len != 0)
        begin
            r.front_value = shadow_words[shadow_len - 1];
            r.back_value  = shadow_words[0];
        end
        r.count = 7'(shadow_len);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] w;
        case ($urandom_range(0, 15))
            0:       w = WORD_MAX;
            1:       w = WORD_MIN;
            2:       w = '0;
            3:       w = -32'sd1;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Builds a command whose position is valid for the current list length.
    function automatic cmd_t legal_cmd(logic [2:0] k);
        cmd_t c;
        c.kind = k;
        c.item = rand_word();
        case (k)
            KIND_INSERT:
                c.position = 7'($urandom_range(0, shadow_len));
            KIND_ERASE, KIND_READ:
                c.position = (shadow_len > 0) ? 7'($urandom_range(0, shadow_len - 1)) : '0;
            default:
                c.position = 7'($urandom_range(0, 127));
        endcase
        return c;
    endfunction

    function automatic cmd_t noise_cmd(logic [2:0] k);
        cmd_t c;
        c.kind     = k;
        c.position = 7'($urandom_range(0, 127));
        c.item     = rand_word();
        return c;
    endfunction

    task automatic add_row(input logic [2:0] k, input int p, input logic signed [31:0] v,
                           input bit typed, input logic signed [31:0] rd,
                           input logic signed [31:0] fr, input logic signed [31:0] bk,
                           input int cnt, input logic [1:0] st);
        dir_row_t row;
        row.c.kind          = k;
        row.c.position      = 7'(p);
        row.c.item          = v;
        row.typed           = typed;
        row.r.read_value    = rd;
        row.r.front_value   = fr;
        row.r.back_value    = bk;
        row.r.count         = 7'(cnt);
        row.r.status        = st;
        directed_q.insert(directed_q.size(), row);
    endtask

    // Sends one command word; the sender runs in bursts with idle gaps between.
    task automatic send_word(input cmd_t c, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = list_apply(c);
        expected_rsp_q.insert(expected_rsp_q.size(), typed ? typed_rsp : predicted);
        burst_left--;
        accepted_cmds++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp_q.size() != 0);
    endtask

    initial
    begin
        int   seq;
        int   n;
        cmd_t c;

        // Empty list: every removal and read is refused, insert above count too.
        add_row(KIND_POP_FRONT, 0, 0, 1, 0, 0, 0, 0, ST_EMPTY);
        add_row(KIND_POP_BACK, 127, WORD_MAX, 1, 0, 0, 0, 0, ST_EMPTY);
        add_row(KIND_ERASE, 0, 0, 1, 0, 0, 0, 0, ST_EMPTY);
        add_row(KIND_READ, 127, 0, 1, 0, 0, 0, 0, ST_EMPTY);
        add_row(KIND_INSERT, 1, 5, 1, 0, 0, 0, 0, ST_RANGE);
        // Insert at zero adds at the back end.
        add_row(KIND_INSERT, 0, WORD_MAX, 1, 0, WORD_MAX, WORD_MAX, 1, ST_OK);
        add_row(KIND_PUSH_FRONT, 127, WORD_MIN, 1, 0, WORD_MIN, WORD_MAX, 2, ST_OK);
        add_row(KIND_PUSH_BACK, 0, -1, 1, 0, WORD_MIN, -1, 3, ST_OK);
        add_row(KIND_READ, 0, 0, 1, -1, WORD_MIN, -1, 3, ST_OK);
        add_row(KIND_READ, 2, 0, 1, WORD_MIN, WORD_MIN, -1, 3, ST_OK);
        add_row(KIND_READ, 3, 0, 1, 0, WORD_MIN, -1, 3, ST_RANGE);
        // Insert at count adds at the front end.
        add_row(KIND_INSERT, 3, 7, 1, 0, 7, -1, 4, ST_OK);
        add_row(KIND_INSERT, 1, 0, 1, 0, 7, -1, 5, ST_OK);
        add_row(KIND_READ, 2, 0, 1, WORD_MAX, 7, -1, 5, ST_OK);
        add_row(KIND_INSERT, 6, 9, 1, 0, 7, -1, 5, ST_RANGE);
        add_row(KIND_ERASE, 5, 0, 1, 0, 7, -1, 5, ST_RANGE);
        add_row(KIND_ERASE, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_ERASE, 3, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_POP_FRONT, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_POP_BACK, 0, 0, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_READ, 0, 32'sh1357_9bdf, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_CLEAR, 64, 0, 1, 0, 0, 0, 0, ST_OK);
        add_row(KIND_CLEAR, 0, 0, 1, 0, 0, 0, 0, ST_OK);
        add_row(KIND_PUSH_BACK, 0, 32'sh1234_5678, 0, 0, 0, 0, 0, ST_OK);
        add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 0, ST_OK);

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
            send_word(directed_q[i].c, directed_q[i].typed, directed_q[i].r);
        wait_drained();

        while (accepted_cmds < directed_q.size() + RANDOM_ITEMS)
        begin
            seq = $urandom_range(0, 19);
            if (seq < 12)
            begin
                n = $urandom_range(10, 40);
                repeat (n)
                begin
                    c = legal_cmd(($urandom_range(0, 49) == 0) ? KIND_CLEAR
                                                               : 3'($urandom_range(0, 6)));
                    send_word(c, 1'b0, '0);
                end
            end
            else if (seq < 14)
            begin
                // Grow to capacity, then knock on the full list.
                while (shadow_len < LIST_CAP)
                    send_word(legal_cmd(grow_kinds[$urandom_range(0, 2)]), 1'b0, '0);
                n = $urandom_range(2, 6);
                repeat (n)
                    send_word(noise_cmd(grow_kinds[$urandom_range(0, 2)]), 1'b0, '0);
            end
            else if (seq < 16)
            begin
                // Shrink to nothing, then probe the empty list.
                while (shadow_len > 0)
                    send_word(legal_cmd(shrink_kinds[$urandom_range(0, 2)]), 1'b0, '0);
                n = $urandom_range(2, 5);
                repeat (n)
                    send_word(noise_cmd(probe_kinds[$urandom_range(0, 3)]), 1'b0, '0);
            end
            else if (seq < 19)
            begin
                n = $urandom_range(5, 15);
                repeat (n)
                    send_word(noise_cmd(3'($urandom_range(0, 7))), 1'b0, '0);
            end
            else
                wait_drained();
        end

        cmd_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // The receiver alternates between solid stalls, free runs and random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       stall_run = $urandom_range(1, 12);
                    1:       stall_run = $urandom_range(30, 100);
                    default: stall_run = $urandom_range(8, 40);
                endcase
            end
            stall_run--;
            case (stall_mode)
                0:       rsp_stall <= 1'b1;
                1:       rsp_stall <= 1'b0;
                default: rsp_stall <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("response word with nothing expected: %p", rsp);
                fail_count++;
            end
            else
            begin
                want_rsp = expected_rsp_q[0];
                expected_rsp_q.delete(0);
                if (rsp.read_value !== want_rsp.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           want_rsp.read_value, rsp.read_value);
                    fail_count++;
                end
                if (rsp.front_value !== want_rsp.front_value)
                begin
                    $error("front_value: expected %0d, got %0d",
                           want_rsp.front_value, rsp.front_value);
                    fail_count++;
                end
                if (rsp.back_value !== want_rsp.back_value)
                begin
                    $error("back_value: expected %0d, got %0d",
                           want_rsp.back_value, rsp.back_value);
                    fail_count++;
                end
                if (rsp.count !== want_rsp.count)
                begin
                    $error("count: expected %0d, got %0d", want_rsp.count, rsp.count);
                    fail_count++;
                end
                if (rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no word accepted for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> files.f
hdl/idl_pkg.sv
hdl/idl_cell.sv
hdl/indexed_deque_list_top.sv
hdl/idl_checker.sv
verif/tb_top.sv
